### hdl/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// property that must hold at every clock edge out of reset
`define ASSERT_AT(name, clk, rstn, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// condition in one cycle implies a condition in the next
`define ASSERT_NEXT(name, clk, rstn, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |=> (post)) \
    else $error(msg);
`else
`define ASSERT_AT(name, clk, rstn, prop, msg)
`define ASSERT_NEXT(name, clk, rstn, pre, post, msg)
`endif
`endif

### hdl/bsrd_pkg.sv
// types and constants of the button sequence reset detector
`default_nettype none
package bsrd_pkg;

  localparam int unsigned CntW   = 16;
  localparam int unsigned HalfW  = 15;
  localparam int unsigned StageW = 3;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_HOLD      = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_TIMEOUT   = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_SLOW_HALF = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_FAST_HALF = 2'd3;

  // register reset values
  localparam logic [CntW-1:0]  HOLD_RST      = 16'd3000;
  localparam logic [CntW-1:0]  TIMEOUT_RST   = 16'd10000;
  localparam logic [HalfW-1:0] SLOW_HALF_RST = 15'd1000;
  localparam logic [HalfW-1:0] FAST_HALF_RST = 15'd50;

  localparam logic [CntW-1:0] CNT_MAX = {CntW{1'b1}};

  // sequence stage codes
  localparam logic [StageW-1:0] ST_IDLE  = 3'd0;
  localparam logic [StageW-1:0] ST_REL1  = 3'd1;
  localparam logic [StageW-1:0] ST_HOLD2 = 3'd2;
  localparam logic [StageW-1:0] ST_REL2  = 3'd3;
  localparam logic [StageW-1:0] ST_HOLD3 = 3'd4;

  typedef struct packed {
    logic [CntW-1:0]  hold_ms;
    logic [CntW-1:0]  timeout_ms;
    logic [HalfW-1:0] slow_half_ms;
    logic [HalfW-1:0] fast_half_ms;
  } cfg_t;

  typedef struct packed {
    logic              led_level;
    logic [StageW-1:0] stage_now;
    logic              reset_request;
  } result_t;

  typedef struct packed {
    logic [StageW-1:0] stage;
    logic              latched;
  } status_t;

endpackage
`default_nettype wire

### hdl/bsrd_channels.sv
// valid/ready channel interfaces for button input and result output
`default_nettype none
interface bsrd_in_if;
  logic valid;
  logic ready;
  logic button_level;
  modport source (output valid, output button_level, input ready);
  modport sink   (input valid, input button_level, output ready);
endinterface

interface bsrd_out_if;
  logic       valid;
  logic       ready;
  logic       led_level;
  logic [2:0] stage_now;
  logic       reset_request;
  modport source (output valid, output led_level, output stage_now,
                  output reset_request, input ready);
  modport sink   (input valid, input led_level, input stage_now,
                  input reset_request, output ready);
endinterface
`default_nettype wire

### hdl/bsrd_cfg.sv
// configuration register file
`default_nettype none
module bsrd_cfg import bsrd_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                we_i,
  input  wire logic [CfgIdxW-1:0]  idx_i,
  input  wire logic [CfgDataW-1:0] data_i,
  output cfg_t                     cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      case (idx_i)
        REG_HOLD:      cfg_d.hold_ms      = data_i;
        REG_TIMEOUT:   cfg_d.timeout_ms   = data_i;
        REG_SLOW_HALF: cfg_d.slow_half_ms = data_i[HalfW-1:0];
        REG_FAST_HALF: cfg_d.fast_half_ms = data_i[HalfW-1:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hold_ms      <= HOLD_RST;
      cfg_q.timeout_ms   <= TIMEOUT_RST;
      cfg_q.slow_half_ms <= SLOW_HALF_RST;
      cfg_q.fast_half_ms <= FAST_HALF_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

### hdl/bsrd_core.sv
// sequence state, counters and per-tick update logic
`default_nettype none
module bsrd_core import bsrd_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire cfg_t cfg_i,
  input  wire logic accept_i,
  input  wire logic button_i,
  output result_t   result_o,
  output status_t   status_o
);

  logic [StageW-1:0] stage_q, stage_d;
  logic              btn_q, btn_d;
  logic [CntW-1:0]   tog_q, tog_d;
  logic [CntW-1:0]   ssc_q, ssc_d;
  logic [CntW-1:0]   slow_q, slow_d;
  logic [CntW-1:0]   fast_q, fast_d;
  logic              latched_q, latched_d;

  logic              held, dwell, recent, led;
  logic [CntW:0]     slow_nx, fast_nx;

  always_comb begin
    stage_d   = stage_q;
    btn_d     = btn_q;
    tog_d     = tog_q;
    ssc_d     = ssc_q;
    slow_d    = slow_q;
    fast_d    = fast_q;
    latched_d = latched_q;
    led       = 1'b0;
    held      = 1'b0;
    dwell     = 1'b0;
    recent    = 1'b0;
    slow_nx   = {1'b0, slow_q} + 17'd1;
    fast_nx   = {1'b0, fast_q} + 17'd1;

    if (!latched_q) begin
      if (button_i != btn_q) begin
        btn_d = button_i;
        tog_d = '0;
      end else begin
        tog_d = (tog_q == CNT_MAX) ? CNT_MAX : tog_q + 16'd1;
      end
      ssc_d = (ssc_q == CNT_MAX) ? CNT_MAX : ssc_q + 16'd1;

      held   = !btn_d && (tog_d >= cfg_i.hold_ms);
      dwell  = ssc_d >= cfg_i.hold_ms;
      recent = tog_d < cfg_i.hold_ms;

      case (stage_q)
        ST_REL1, ST_REL2: begin
          led = fast_q >= {1'b0, cfg_i.fast_half_ms};
          if (dwell && recent) begin
            stage_d = stage_q + 3'd1;
            ssc_d   = '0;
          end
        end
        ST_HOLD2: begin
          led = 1'b1;
          if (held) begin
            stage_d = ST_REL2;
            ssc_d   = '0;
          end
        end
        ST_HOLD3: begin
          led = 1'b1;
          if (held) begin
            led       = 1'b0;
            stage_d   = ST_IDLE;
            ssc_d     = '0;
            latched_d = 1'b1;
          end
        end
        default: begin
          // idle, and any code that cannot arise
          led     = slow_q >= {1'b0, cfg_i.slow_half_ms};
          stage_d = held ? ST_REL1 : ST_IDLE;
          if (held) ssc_d = '0;
        end
      endcase

      if (ssc_d >= cfg_i.timeout_ms) begin
        ssc_d   = '0;
        stage_d = ST_IDLE;
      end

      slow_d = (slow_nx >= {1'b0, cfg_i.slow_half_ms, 1'b0}) ? '0 : slow_nx[CntW-1:0];
      fast_d = (fast_nx >= {1'b0, cfg_i.fast_half_ms, 1'b0}) ? '0 : fast_nx[CntW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q   <= ST_IDLE;
      btn_q     <= 1'b0;
      tog_q     <= '0;
      ssc_q     <= '0;
      slow_q    <= '0;
      fast_q    <= '0;
      latched_q <= 1'b0;
    end else if (accept_i) begin
      stage_q   <= stage_d;
      btn_q     <= btn_d;
      tog_q     <= tog_d;
      ssc_q     <= ssc_d;
      slow_q    <= slow_d;
      fast_q    <= fast_d;
      latched_q <= latched_d;
    end
  end

  assign result_o.led_level     = led;
  assign result_o.stage_now     = stage_d;
  assign result_o.reset_request = latched_d;

  assign status_o.stage   = stage_q;
  assign status_o.latched = latched_q;

endmodule
`default_nettype wire

### hdl/bsrd_skid.sv
// two-entry result register with skid slot
`default_nettype none
module bsrd_skid import bsrd_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire result_t in_data_i,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  output result_t      out_data_o
);

  logic    main_vld_q, main_vld_d;
  logic    skid_vld_q, skid_vld_d;
  result_t main_q, main_d;
  result_t skid_q, skid_d;
  logic    push, pop;

  assign in_ready_o = !skid_vld_q;
  assign push       = in_valid_i && in_ready_o;
  assign pop        = main_vld_q && out_ready_i;

  always_comb begin
    main_vld_d = main_vld_q;
    skid_vld_d = skid_vld_q;
    main_d     = main_q;
    skid_d     = skid_q;
    if (pop) begin
      main_vld_d = skid_vld_q;
      main_d     = skid_q;
      skid_vld_d = 1'b0;
    end
    if (push) begin
      if (!main_vld_d) begin
        main_vld_d = 1'b1;
        main_d     = in_data_i;
      end else begin
        skid_vld_d = 1'b1;
        skid_d     = in_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      main_vld_q <= main_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = main_vld_q;
  assign out_data_o  = main_q;

endmodule
`default_nettype wire

### hdl/button_sequence_reset_detector_unit.sv
// top level of the button sequence reset detector
//
// one input transaction per millisecond tick carries the active-low button
// level; each accepted transaction yields exactly one result transaction with
// the led drive, the stage after the tick and the latched reset request.
// the state update is done in the cycle of acceptance and the result lands in
// an output register, and a new input can be taken every cycle while the
// skid slot is free. the per-tick update is set by the saturating counter
// and compare logic in front of the state registers.
// a two-entry result buffer parts the sides: when the receiver stalls, one
// more input is still taken into the skid slot, then input ready drops until
// the receiver takes a result.
// configuration writes (hold, timeout, slow and fast blink half periods) go
// through the plain write port and are meant for an idle block.
// reset clears the sequence state, counters, blink phases and request, and
// loads the registers with their defaults (3000, 10000, 1000, 50 ms).
// after the full sequence the request latches and the block freezes,
// answering led off, stage 0, request set on every further tick.
`default_nettype none
`include "assert_macros.svh"
module button_sequence_reset_detector_unit import bsrd_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  bsrd_in_if.sink                  in_i,
  bsrd_out_if.source               out_o
);

  cfg_t    cfg;
  result_t core_res;
  result_t out_res;
  status_t status;
  logic    in_ready;
  logic    in_accept;

  // register file
  bsrd_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (cfg_we_i),
    .idx_i  (cfg_idx_i),
    .data_i (cfg_data_i),
    .cfg_o  (cfg)
  );

  assign in_i.ready = in_ready;
  assign in_accept  = in_i.valid && in_ready;

  // state update happens in the cycle the input transaction is accepted
  bsrd_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .accept_i (in_accept),
    .button_i (in_i.button_level),
    .result_o (core_res),
    .status_o (status)
  );

  // result register with skid slot towards the receiver
  bsrd_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_accept),
    .in_ready_o  (in_ready),
    .in_data_i   (core_res),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_data_o  (out_res)
  );

  assign out_o.led_level     = out_res.led_level;
  assign out_o.stage_now     = out_res.stage_now;
  assign out_o.reset_request = out_res.reset_request;

  // the request never clears once latched
  `ASSERT_NEXT(a_latch_sticky, clk_i, rst_ni, status.latched, status.latched,
               "reset request dropped after latching")
  // the stage stays within the five legal codes
  `ASSERT_AT(a_stage_legal, clk_i, rst_ni, status.stage <= ST_HOLD3,
             "stage code out of range")
  // a latched request always reports led off and stage zero
  `ASSERT_AT(a_req_result, clk_i, rst_ni,
             !(out_o.valid && out_o.reset_request) ||
             (!out_o.led_level && out_o.stage_now == ST_IDLE),
             "request result with led lit or stage not idle")
  // input back-pressure only while a result is waiting
  `ASSERT_AT(a_ready_full, clk_i, rst_ni, in_ready || out_o.valid,
             "input stalled with no pending result")

endmodule
`default_nettype wire

### tb/button_sequence_reset_detector_unit_test.sv
// self-checking testbench for the button sequence reset detector unit
module button_sequence_reset_detector_unit_test;
  import bsrd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // results that can be read off directly, used by the directed table
  localparam result_t IDLE_DARK = '{led_level: 1'b0, stage_now: ST_IDLE, reset_request: 1'b0};
  localparam result_t IDLE_LIT  = '{led_level: 1'b1, stage_now: ST_IDLE, reset_request: 1'b0};
  localparam result_t SEQ_DONE  = '{led_level: 1'b0, stage_now: ST_IDLE, reset_request: 1'b1};

  localparam int unsigned PhaseTicks = 150;
  localparam int unsigned PhaseCount = 12;

  typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_e;

  // one row of the directed table: a tick or a register write
  typedef struct {
    row_kind_e            kind;
    logic                 btn;
    logic [CfgIdxW-1:0]   idx;
    logic [CfgDataW-1:0]  data;
    logic                 typed;
    result_t              want;
  } stim_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  bsrd_in_if  button_ch ();
  bsrd_out_if result_ch ();

  button_sequence_reset_detector_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (button_ch),
    .out_o      (result_ch)
  );

  // ---------------------------------------------------------------------------
  // tracker state: our own copy of the sequence state and the registers
  // ---------------------------------------------------------------------------
  cfg_t              det_cfg;
  logic [StageW-1:0] det_stage;
  logic              det_button;
  logic [CntW-1:0]   det_since_toggle;
  logic [CntW-1:0]   det_since_stage;
  logic [CntW-1:0]   det_slow_phase;
  logic [CntW-1:0]   det_fast_phase;
  logic              det_latched;

  // results still owed by the block, oldest first
  result_t pending_results[$];
  stim_row_t stim_table[$];
  int unsigned closing_start;

  int unsigned mismatch_count;
  int unsigned ticks_sent;
  int unsigned results_checked;
  int unsigned settings_used;
  int unsigned send_idle_pct;
  int unsigned stall_pct;

  // random button pattern: current level and ticks left in the segment
  logic        gen_level;
  int unsigned gen_left;

  // ---------------------------------------------------------------------------
  // clock
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // tracker of the detector
  // ---------------------------------------------------------------------------
  function void clear_tracker();
    det_cfg          = '{HOLD_RST, TIMEOUT_RST, SLOW_HALF_RST, FAST_HALF_RST};
    det_stage        = ST_IDLE;
    det_button       = 1'b0;
    det_since_toggle = '0;
    det_since_stage  = '0;
    det_slow_phase   = '0;
    det_fast_phase   = '0;
    det_latched      = 1'b0;
  endfunction

  function automatic logic [CntW-1:0] sat_count(input logic [CntW-1:0] v);
    return (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

  // blink phase runs 0 .. 2*half-1 and wraps; an out-of-range phase wraps too
  function automatic logic [CntW-1:0] blink_step(input logic [CntW-1:0] ph,
                                                 input logic [HalfW-1:0] half);
    int unsigned n;
    n = int'(ph) + 1;
    return (n >= 2 * int'(half)) ? '0 : n[CntW-1:0];
  endfunction

  function void note_register(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    case (idx)
      REG_HOLD:      det_cfg.hold_ms      = data;
      REG_TIMEOUT:   det_cfg.timeout_ms   = data;
      REG_SLOW_HALF: det_cfg.slow_half_ms = data[HalfW-1:0];
      REG_FAST_HALF: det_cfg.fast_half_ms = data[HalfW-1:0];
      default: ;
    endcase
  endfunction

  // one millisecond tick of the detector, returns the led, stage and request
  function result_t detector_tick(input logic btn);
    logic    led;
    logic    held;
    logic    dwell;
    logic    recent;
    result_t r;
    if (det_latched) begin
      return SEQ_DONE;
    end
    if (btn != det_button) begin
      det_button       = btn;
      det_since_toggle = '0;
    end else begin
      det_since_toggle = sat_count(det_since_toggle);
    end
    det_since_stage = sat_count(det_since_stage);

    held   = !det_button && (det_since_toggle >= det_cfg.hold_ms);
    dwell  = det_since_stage >= det_cfg.hold_ms;
    recent = det_since_toggle < det_cfg.hold_ms;

    // led comes from the stage at the start of the tick
    case (det_stage)
      ST_REL1, ST_REL2: begin
        led = det_fast_phase >= CntW'(det_cfg.fast_half_ms);
        if (dwell && recent) begin
          det_stage       = det_stage + 1'b1;
          det_since_stage = '0;
        end
      end
      ST_HOLD2: begin
        led = 1'b1;
        if (held) begin
          det_stage       = ST_REL2;
          det_since_stage = '0;
        end
      end
      ST_HOLD3: begin
        led = 1'b1;
        if (held) begin
          led             = 1'b0;
          det_stage       = ST_IDLE;
          det_since_stage = '0;
          det_latched     = 1'b1;
        end
      end
      default: begin
        led       = det_slow_phase >= CntW'(det_cfg.slow_half_ms);
        det_stage = ST_IDLE;
        if (held) begin
          det_stage       = ST_REL1;
          det_since_stage = '0;
        end
      end
    endcase

    if (det_since_stage >= det_cfg.timeout_ms) begin
      det_since_stage = '0;
      det_stage       = ST_IDLE;
    end

    det_slow_phase = blink_step(det_slow_phase, det_cfg.slow_half_ms);
    det_fast_phase = blink_step(det_fast_phase, det_cfg.fast_half_ms);

    r.led_level     = led;
    r.stage_now     = det_stage;
    r.reset_request = det_latched;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // directed table helpers
  // ---------------------------------------------------------------------------
  function automatic stim_row_t tick_row(input logic btn);
    stim_row_t row;
    row       = '{ROW_TICK, btn, '0, '0, 1'b0, '0};
    return row;
  endfunction

  function automatic stim_row_t checked_row(input logic btn, input result_t want);
    stim_row_t row;
    row       = '{ROW_TICK, btn, '0, '0, 1'b1, want};
    return row;
  endfunction

  function automatic stim_row_t write_row(input logic [CfgIdxW-1:0] idx,
                                          input logic [CfgDataW-1:0] data);
    stim_row_t row;
    row       = '{ROW_WRITE, 1'b0, idx, data, 1'b0, '0};
    return row;
  endfunction

  // ---------------------------------------------------------------------------
  // random button pattern: mostly press-for-hold / short-release pairs that
  // walk the sequence, the rest noise; never press in the last stage so the
  // request stays clear until the closing part
  // ---------------------------------------------------------------------------
  function logic next_button();
    int unsigned hold;
    logic        btn;
    hold = det_cfg.hold_ms;
    if (gen_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        gen_level = ~gen_level;
        gen_left  = !gen_level ? hold + $urandom_range(1, 3) : $urandom_range(1, hold + 2);
      end else begin
        gen_level = 1'($urandom_range(0, 1));
        gen_left  = $urandom_range(1, 2 * hold + 3);
      end
    end
    gen_left = gen_left - 1;
    btn      = gen_level;
    if (det_stage == ST_HOLD3) begin
      btn = 1'b1;
    end
    return btn;
  endfunction

  function automatic logic [CfgDataW-1:0] pick_half();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return 16'hFFFF;
      2:       return CfgDataW'($urandom_range(100, 2000));
      default: return CfgDataW'($urandom_range(1, 30));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // driving tasks, all entered and left at a falling edge
  // ---------------------------------------------------------------------------

  // one button transaction; the tracker runs on acceptance
  task automatic send_tick(input logic btn, input logic typed, input result_t want);
    result_t predicted;
    while ($urandom_range(1, 100) <= send_idle_pct) begin
      button_ch.valid        <= 1'b0;
      button_ch.button_level <= 1'($urandom_range(0, 1));
      @(negedge clk_i);
    end
    button_ch.valid        <= 1'b1;
    button_ch.button_level <= btn;
    @(posedge clk_i);
    while (!button_ch.ready) @(posedge clk_i);
    predicted = detector_tick(btn);
    pending_results.push_back(typed ? want : predicted);
    ticks_sent++;
    @(negedge clk_i);
  endtask

  // sender holds off until every owed result is in, plus the output latency
  task automatic pause_until_drained();
    button_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    note_register(idx, data);
    @(negedge clk_i);
  endtask

  task automatic walk_rows(input int unsigned first, input int unsigned last);
    logic last_was_write;
    last_was_write = 1'b0;
    for (int unsigned i = first; i < last; i++) begin
      if (stim_table[i].kind == ROW_WRITE) begin
        if (!last_was_write) begin
          pause_until_drained();
        end
        write_reg(stim_table[i].idx, stim_table[i].data);
        last_was_write = 1'b1;
      end else begin
        send_tick(stim_table[i].btn, stim_table[i].typed, stim_table[i].want);
        last_was_write = 1'b0;
      end
    end
  endtask

  task automatic set_idling(input int unsigned mode);
    case (mode % 4)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 66; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 66; end
      default: begin send_idle_pct = 32; stall_pct = 32; end
    endcase
  endtask

  // one random phase: fresh registers, one idling mode, a drain half way
  task automatic run_phase(input int unsigned ph);
    logic [CfgDataW-1:0] hold;
    logic [CfgDataW-1:0] tmo;
    logic [CfgDataW-1:0] slow;
    logic [CfgDataW-1:0] fast;
    case ($urandom_range(0, 9))
      0:       hold = '0;
      1:       hold = 16'd1;
      default: hold = CfgDataW'($urandom_range(2, 12));
    endcase
    case ($urandom_range(0, 7))
      0:       tmo = 16'hFFFF;
      1:       tmo = CfgDataW'($urandom_range(0, hold));
      default: tmo = CfgDataW'(hold * $urandom_range(3, 8) + $urandom_range(0, 5));
    endcase
    slow = pick_half();
    fast = pick_half();
    // long periods first so the phases run far, then short ones so they overshoot
    if (ph == 0) begin
      slow = CfgDataW'($urandom_range(200, 32767));
      fast = CfgDataW'($urandom_range(200, 32767));
    end else if (ph == 1) begin
      slow = CfgDataW'($urandom_range(1, 8));
      fast = CfgDataW'($urandom_range(1, 8));
    end

    pause_until_drained();
    write_reg(REG_HOLD, hold);
    write_reg(REG_TIMEOUT, tmo);
    write_reg(REG_SLOW_HALF, slow);
    write_reg(REG_FAST_HALF, fast);
    settings_used++;
    set_idling(ph);

    for (int unsigned i = 0; i < PhaseTicks; i++) begin
      if (i == PhaseTicks / 2) begin
        pause_until_drained();
      end
      send_tick(next_button(), 1'b0, '0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // receiver: ready changes at the falling edge, stalls per the current mode
  // ---------------------------------------------------------------------------
  initial begin
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      result_ch.ready <= ($urandom_range(1, 100) > stall_pct);
    end
  end

  task automatic check_field(input string name, input int unsigned exp, input int unsigned act);
    if (exp != act) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp, act);
      mismatch_count++;
    end
  endtask

  // each result transaction is compared with the oldest owed result
  always @(posedge clk_i) begin : check_results
    result_t want;
    if (result_ch.valid && result_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got led %0d stage %0d request %0d",
                 $time, result_ch.led_level, result_ch.stage_now, result_ch.reset_request);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("led_level", want.led_level, result_ch.led_level);
        check_field("stage_now", want.stage_now, result_ch.stage_now);
        check_field("reset_request", want.reset_request, result_ch.reset_request);
        results_checked++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // run limit
  // ---------------------------------------------------------------------------
  initial begin
    #2000000;
    $display("run limit reached with %0d results outstanding", pending_results.size());
    $display("end of test: mismatches");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni                 = 1'b0;
    cfg_we_i               = 1'b0;
    cfg_idx_i              = '0;
    cfg_data_i             = '0;
    button_ch.valid        = 1'b0;
    button_ch.button_level = 1'b0;
    mismatch_count         = 0;
    ticks_sent             = 0;
    results_checked        = 0;
    settings_used          = 1;
    send_idle_pct          = 0;
    stall_pct              = 0;
    gen_level              = 1'b1;
    gen_left               = 0;
    clear_tracker();

    // opening rows: defaults after reset
    stim_table.push_back(checked_row(1'b0, IDLE_DARK));
    stim_table.push_back(checked_row(1'b1, IDLE_DARK));
    stim_table.push_back(checked_row(1'b0, IDLE_DARK));
    // zero hold and zero timeout: a press advances but the stage falls straight back
    stim_table.push_back(write_row(REG_HOLD, '0));
    stim_table.push_back(write_row(REG_TIMEOUT, '0));
    stim_table.push_back(tick_row(1'b0));
    stim_table.push_back(tick_row(1'b1));
    // zero half periods light the led steadily, widest timeout
    stim_table.push_back(write_row(REG_SLOW_HALF, '0));
    stim_table.push_back(write_row(REG_FAST_HALF, '0));
    stim_table.push_back(write_row(REG_TIMEOUT, 16'hFFFF));
    stim_table.push_back(checked_row(1'b1, IDLE_LIT));
    stim_table.push_back(tick_row(1'b0));
    // zero hold: the release condition never holds, so the stage sticks
    stim_table.push_back(tick_row(1'b1));
    // hold of one walks through every stage up to the last, released there
    stim_table.push_back(write_row(REG_HOLD, 16'd1));
    stim_table.push_back(tick_row(1'b0));
    stim_table.push_back(tick_row(1'b0));
    stim_table.push_back(tick_row(1'b1));
    stim_table.push_back(tick_row(1'b1));
    stim_table.push_back(tick_row(1'b1));
    // top data bit is dropped by the half period registers
    stim_table.push_back(write_row(REG_FAST_HALF, 16'hFFFF));
    stim_table.push_back(write_row(REG_SLOW_HALF, 16'd1));
    stim_table.push_back(tick_row(1'b1));

    // closing rows: force stage 0, then the full sequence with hold of two
    closing_start = stim_table.size();
    stim_table.push_back(write_row(REG_TIMEOUT, 16'd1));
    stim_table.push_back(write_row(REG_HOLD, 16'd2));
    stim_table.push_back(tick_row(1'b1));
    stim_table.push_back(tick_row(1'b1));
    stim_table.push_back(write_row(REG_TIMEOUT, 16'hFFFF));
    // first hold
    stim_table.push_back(tick_row(1'b0));
    stim_table.push_back(tick_row(1'b0));
    stim_table.push_back(tick_row(1'b0));
    // dwell then release
    stim_table.push_back(tick_row(1'b0));
    stim_table.push_back(tick_row(1'b1));
    // second hold
    stim_table.push_back(tick_row(1'b0));
    stim_table.push_back(tick_row(1'b0));
    stim_table.push_back(tick_row(1'b0));
    // dwell then release
    stim_table.push_back(tick_row(1'b0));
    stim_table.push_back(tick_row(1'b1));
    // final hold, completion on the third tick
    stim_table.push_back(tick_row(1'b0));
    stim_table.push_back(tick_row(1'b0));
    stim_table.push_back(checked_row(1'b0, SEQ_DONE));
    // frozen afterwards whatever the button does
    stim_table.push_back(checked_row(1'b1, SEQ_DONE));
    stim_table.push_back(checked_row(1'b0, SEQ_DONE));
    stim_table.push_back(checked_row(1'b1, SEQ_DONE));

    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    walk_rows(0, closing_start);

    for (int unsigned ph = 0; ph < PhaseCount; ph++) begin
      run_phase(ph);
    end

    set_idling(3);
    settings_used++;
    walk_rows(closing_start, stim_table.size());

    pause_until_drained();
    repeat (8) @(negedge clk_i);

    $display("%0d ticks driven, %0d results compared over %0d register settings,",
             ticks_sent, results_checked, settings_used);
    $display("with idle and stall mixes, blink wrap edge cases and one completed sequence");
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
